### rtl/awbg_pkg.sv
// awbg_pkg: shared types, constants and arithmetic for the white-balance gain block.
// No dependencies. The modules of the block refer to it by scoped names.
`default_nettype none
package awbg_pkg;
	localparam int RATIO_BITS_DEF = 16;
	localparam logic [15:0] UNITY_GAIN = 16'h0100;
	localparam logic [15:0] QUOT_MAX = 16'hFFFF;
	localparam logic [15:0] TYP_R_RESET = 16'h0249;
	localparam logic [15:0] TYP_B_RESET = 16'h0232;
	localparam int QDEPTH = 4;

	typedef enum logic [0:0] {
		CFG_TYP_R = 1'b0,
		CFG_TYP_B = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] red_ratio;
		logic [15:0] blue_ratio;
	} awbg_in_t;

	typedef struct packed {
		logic [15:0] red_gain;
		logic [15:0] green_gain;
		logic [15:0] blue_gain;
		logic        divide_fault;
	} awbg_out_t;

	// Case code formed by the front end; one-hot.
	typedef enum logic [3:0] {
		CASE_BOTH_LOW = 4'b0001,  // green pinned
		CASE_R_HIGH   = 4'b0010,  // red pinned, green from red
		CASE_B_HIGH   = 4'b0100,  // blue pinned, green from blue
		CASE_BOTH_HI  = 4'b1000   // larger green candidate wins
	} awbg_case_t;

	// Classified request handed from front to back through the queue.
	typedef struct packed {
		awbg_case_t  kind;
		logic [15:0] rr;
		logic [15:0] br;
		logic [15:0] rt;
		logic [15:0] bt;
	} awbg_job_t;
endpackage
`default_nettype wire

### rtl/awbg_div.sv
// awbg_div: pipelined restoring divider, one quotient bit per stage, 32b / 16b.
// Output saturates to 16 bits; zero divisor gives all-ones and a fault bit.
// Depends on awbg_pkg. Sideband travels alongside.
`default_nettype none
module awbg_div #(
	parameter int SB_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [31:0]        num,
	input  wire logic [15:0]        den,
	input  wire logic [SB_BITS-1:0] sb_in,
	output logic [15:0]             quot,
	output logic                    zero,
	output logic [SB_BITS-1:0]      sb_out
);
	localparam int N = 32;
	// stage k holds partial remainder (17b) and quotient bits
	logic [16:0]        rem_s [N+1];
	logic [N-1:0]       num_s [N+1];
	logic [15:0]        den_s [N+1];
	logic [SB_BITS-1:0] sb_s  [N+1];

	always_comb begin
		rem_s[0] = '0;
		num_s[0] = num;
		den_s[0] = den;
		sb_s[0]  = sb_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [16:0] sh;
		logic [17:0] diff;
		assign sh = {rem_s[k][15:0], num_s[k][N-1]};
		assign diff = {1'b0, sh} - {2'b00, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[17] ? sh : diff[16:0];
				num_s[k+1] <= {num_s[k][N-2:0], ~diff[17]};
				den_s[k+1] <= den_s[k];
			end
		end
		// sideband carries the valid bit, so it is reset
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[k+1] <= '0;
			end else if (en) begin
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign zero = (den_s[N] == '0);
	assign quot = (zero || (num_s[N][31:16] != '0)) ? awbg_pkg::QUOT_MAX : num_s[N][15:0];
	assign sb_out = sb_s[N];
endmodule
`default_nettype wire

### rtl/awbg_front.sv
// awbg_front: masks ratios to RATIO_BITS, holds the typical-ratio registers
// and classifies each request into one of four cases. Depends on awbg_pkg.
`default_nettype none
module awbg_front #(
	parameter int RATIO_BITS = awbg_pkg::RATIO_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_idx,
	input  wire logic [15:0]         cfg_data,
	input  wire awbg_pkg::awbg_in_t  req,
	output awbg_pkg::awbg_job_t      job
);
	localparam logic [15:0] MASK = 16'((32'd1 << RATIO_BITS) - 1);
	logic [15:0] typ_r_q, typ_b_q;
	logic [15:0] rr, br, rt, bt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			typ_r_q <= awbg_pkg::TYP_R_RESET;
			typ_b_q <= awbg_pkg::TYP_B_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				awbg_pkg::CFG_TYP_R: typ_r_q <= cfg_data;
				awbg_pkg::CFG_TYP_B: typ_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rr = req.red_ratio & MASK;
		br = req.blue_ratio & MASK;
		rt = typ_r_q & MASK;
		bt = typ_b_q & MASK;
		job.rr = rr;
		job.br = br;
		job.rt = rt;
		job.bt = bt;
		if (br < bt) job.kind = (rr < rt) ? awbg_pkg::CASE_BOTH_LOW : awbg_pkg::CASE_R_HIGH;
		else         job.kind = (rr < rt) ? awbg_pkg::CASE_B_HIGH : awbg_pkg::CASE_BOTH_HI;
	end
endmodule
`default_nettype wire

### rtl/awbg_queue.sv
// awbg_queue: small FIFO of classified requests between front and back.
// Depends on awbg_pkg for the request type and depth.
`default_nettype none
module awbg_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire awbg_pkg::awbg_job_t wdata,
	input  wire logic                pop,
	output awbg_pkg::awbg_job_t      rdata,
	output logic                     full,
	output logic                     empty
);
	localparam int D = awbg_pkg::QDEPTH;
	localparam int AW = $clog2(D);
	awbg_pkg::awbg_job_t mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(D));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) if (push) mem_q[wp_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	ap_no_ovf: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push || pop)
		else $error("queue overflow");
	ap_no_unf: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue underflow");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(D))
		else $error("queue count out of range");
endmodule
`default_nettype wire

### rtl/awbg_back.sv
// awbg_back: executes a classified request through two pipelined divider ranks,
// then clamps to unity. Fixed latency, stalls as a whole. Depends on awbg_pkg, awbg_div.
`default_nettype none
module awbg_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                job_vld,
	input  wire awbg_pkg::awbg_job_t job,
	output logic                     res_vld,
	output awbg_pkg::awbg_out_t      res
);
	// rank one sideband: A carries valid, kind, rt, bt; B carries rr, br
	localparam int SBA = 1 + 4 + 32;
	localparam int SBB = 32;
	// rank two sideband: valid, second-div-used, to_red, fault, g, r, b
	localparam int SB2 = 4 + 48;
	// rank one: two dividers (a: 256*rt/rr or 256*rr/rt, b: 256*bt/br or 256*br/bt)
	logic [15:0] qa, qb, qc;
	logic za, zb, zc;
	logic [SBA-1:0] sba_in, sba_out;
	logic [SBB-1:0] sbb_in, sbb_out;
	logic [31:0] na, nb;
	logic [15:0] da, db;
	awbg_pkg::awbg_case_t k0;
	assign k0 = job.kind;

	always_comb begin
		// divider A: red side; B: blue side
		if (k0 == awbg_pkg::CASE_BOTH_LOW) begin
			na = {8'd0, job.rt, 8'd0}; da = job.rr;
			nb = {8'd0, job.bt, 8'd0}; db = job.br;
		end else begin
			na = {8'd0, job.rr, 8'd0}; da = job.rt;
			nb = {8'd0, job.br, 8'd0}; db = job.bt;
		end
	end
	assign sba_in = {job_vld, job.kind, job.rt, job.bt};
	assign sbb_in = {job.rr, job.br};

	awbg_div #(.SB_BITS(SBA)) u_da (.clk, .arst_n, .en, .num(na), .den(da),
		.sb_in(sba_in), .quot(qa), .zero(za), .sb_out(sba_out));
	awbg_div #(.SB_BITS(SBB)) u_db (.clk, .arst_n, .en, .num(nb), .den(db),
		.sb_in(sbb_in), .quot(qb), .zero(zb), .sb_out(sbb_out));

	// rank two: green times typical over measured
	awbg_pkg::awbg_case_t k1;
	logic [3:0] k1_raw;
	logic v1;
	logic [15:0] rt1, bt1, rr1, br1, gg1, r1, b1;
	logic pick_b, f1, to_red;
	logic [31:0] prod, n2;
	logic [15:0] d2;
	assign {v1, k1_raw, rt1, bt1} = sba_out;
	assign {rr1, br1} = sbb_out;
	assign k1 = awbg_pkg::awbg_case_t'(k1_raw);
	assign pick_b = (k1 == awbg_pkg::CASE_B_HIGH) ||
		((k1 == awbg_pkg::CASE_BOTH_HI) && (qb > qa));

	always_comb begin
		f1 = 1'b0;
		gg1 = awbg_pkg::UNITY_GAIN;
		r1 = awbg_pkg::UNITY_GAIN;
		b1 = awbg_pkg::UNITY_GAIN;
		to_red = 1'b0;
		case (k1)
			awbg_pkg::CASE_BOTH_LOW: begin
				r1 = qa; b1 = qb; f1 = za | zb;
			end
			awbg_pkg::CASE_R_HIGH: begin
				gg1 = qa; f1 = za;
			end
			awbg_pkg::CASE_B_HIGH: begin
				gg1 = qb; f1 = zb; to_red = 1'b1;
			end
			awbg_pkg::CASE_BOTH_HI: begin
				gg1 = pick_b ? qb : qa; f1 = za | zb; to_red = pick_b;
			end
			default: ;
		endcase
	end

	logic [31:0] gt_s1;
	logic [15:0] d_s1;
	logic [SB2-1:0] sb2_in;
	logic mul_vld_s1;
	assign prod = 32'(gg1) * 32'(to_red ? rt1 : bt1);
	always_ff @(posedge clk) begin
		if (en) begin
			gt_s1 <= prod;
			d_s1 <= to_red ? rr1 : br1;
		end
	end
	logic [15:0] g_s1, r_s1, b_s1;
	logic f_s1, use2_s1, tr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_vld_s1 <= 1'b0;
		else if (en) mul_vld_s1 <= v1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= gg1; r_s1 <= r1; b_s1 <= b1; f_s1 <= f1;
			use2_s1 <= (k1 != awbg_pkg::CASE_BOTH_LOW);
			tr_s1 <= to_red;
		end
	end
	assign sb2_in = {mul_vld_s1, use2_s1, tr_s1, f_s1, g_s1, r_s1, b_s1};
	assign n2 = gt_s1;
	assign d2 = d_s1;

	logic [SB2-1:0] sb2_out;
	awbg_div #(.SB_BITS(SB2)) u_dc (.clk, .arst_n, .en, .num(n2), .den(d2),
		.sb_in(sb2_in), .quot(qc), .zero(zc), .sb_out(sb2_out));

	logic v2, u2, tr2, f2;
	logic [15:0] g2, r2, b2, rf, bf;
	assign {v2, u2, tr2, f2, g2, r2, b2} = sb2_out;
	assign rf = (u2 && tr2) ? qc : r2;
	assign bf = (u2 && !tr2) ? qc : b2;

	function automatic logic [15:0] clampu(input logic [15:0] g);
		return (g < awbg_pkg::UNITY_GAIN) ? awbg_pkg::UNITY_GAIN : g;
	endfunction

	assign res_vld = v2;
	assign res.red_gain = clampu(rf);
	assign res.green_gain = clampu(g2);
	assign res.blue_gain = clampu(bf);
	assign res.divide_fault = f2 | (u2 & zc);

	ap_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && res.divide_fault == 1'b0) |-> res.red_gain != 16'h0)
		else $error("gain zero without fault");
	ap_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (res.green_gain >= awbg_pkg::UNITY_GAIN))
		else $error("green below unity");
	ap_pin: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (res.red_gain == awbg_pkg::UNITY_GAIN || res.green_gain ==
		awbg_pkg::UNITY_GAIN || res.blue_gain == awbg_pkg::UNITY_GAIN))
		else $error("no channel pinned at unity");
endmodule
`default_nettype wire

### rtl/awb_gain_from_otp_ratios.sv
// awb_gain_from_otp_ratios: top level of the white-balance gain block.
// Depends on awbg_pkg, awbg_front, awbg_queue, awbg_back.
//
// Usage:
//  - in_valid/in_stall carry a request {red_ratio, blue_ratio}; accepted when
//    in_valid && !in_stall. out_valid/out_stall carry the result
//    {red_gain, green_gain, blue_gain, divide_fault} the same way.
//  - cfg_we/cfg_idx/cfg_data write typical_r_over_g (0) and typical_b_over_g
//    (1); unknown indexes are ignored. Write only while idle.
//  - Throughput: one request per cycle unless out_stall freezes the back. The
//    front classifies in the accept cycle into a 4-entry queue; the back runs
//    two ranks of 32-stage bit-per-cycle dividers plus one multiply register.
//  - Path: the queue register, the first divider rank, the multiply register,
//    the second divider rank and the output register.
//  - When out_stall is high while a result is held, the back pipeline freezes
//    as a unit; the queue fills and in_stall rises when it is full.
//  - Reset clears valids, queue pointers and restores typical ratios
//    (0x249, 0x232). No clearing pass is needed.
`default_nettype none
module awb_gain_from_otp_ratios #(
	parameter int RATIO_BITS = awbg_pkg::RATIO_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire awbg_pkg::awbg_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output awbg_pkg::awbg_out_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_idx,
	input  wire logic [15:0]         cfg_data
);
	awbg_pkg::awbg_job_t job_f, job_q;
	logic q_full, q_empty, push, pop, en, res_vld;
	awbg_pkg::awbg_out_t res;
	logic ov_q;
	awbg_pkg::awbg_out_t od_q;

	awbg_front #(.RATIO_BITS(RATIO_BITS)) u_front (.clk, .arst_n, .cfg_we, .cfg_idx,
		.cfg_data, .req(in_data), .job(job_f));

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	awbg_queue u_queue (.clk, .arst_n, .push, .wdata(job_f), .pop, .rdata(job_q),
		.full(q_full), .empty(q_empty));

	// back advances when the output register can take what falls out
	assign en = !ov_q || !out_stall;
	assign pop = en && !q_empty;

	awbg_back u_back (.clk, .arst_n, .en, .job_vld(!q_empty), .job(job_q),
		.res_vld, .res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= res_vld;
	end
	always_ff @(posedge clk) if (en) od_q <= res;

	assign out_valid = ov_q;
	assign out_data = od_q;

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");
	ap_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop)
		else $error("queue popped while back frozen");
	ap_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !push)
		else $error("push while stalled");
endmodule
`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for awb_gain_from_otp_ratios.
// Depends on awbg_pkg and the block's RTL. Predicts gains per request and
// checks every result in order under random idling, stalls and config changes.
`timescale 1ns / 100ps
module tb_top;
	localparam int LATENCY = 80;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	awbg_pkg::awbg_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	awbg_pkg::awbg_out_t out_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = awbg_pkg::CFG_TYP_R;
	logic [15:0] cfg_data = '0;

	awb_gain_from_otp_ratios dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Local copy of the typical ratios, updated with every register write
	logic [15:0] typ_r = awbg_pkg::TYP_R_RESET;
	logic [15:0] typ_b = awbg_pkg::TYP_B_RESET;

	awbg_pkg::awbg_in_t  pending_reqs[$];
	awbg_pkg::awbg_out_t expected_gains[$];
	int errors = 0;
	int idle_pct = 0;   // sender idle percentage
	int stall_pct = 0;  // receiver stall percentage
	int hold_off = 0;   // cycles of forced receiver stall
	longint cycles = 0;

	// (a*b)/d saturated to 16 bits; zero divisor gives max and flags a fault
	function automatic logic [15:0] muldiv(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] d, inout logic fault);
		logic [31:0] q;
		if (d == 16'd0) begin
			fault = 1'b1;
			return awbg_pkg::QUOT_MAX;
		end
		q = (32'(a) * 32'(b)) / 32'(d);
		return (q > 32'hFFFF) ? awbg_pkg::QUOT_MAX : q[15:0];
	endfunction

	function automatic logic [15:0] clamp_unity(input logic [15:0] g);
		return (g < awbg_pkg::UNITY_GAIN) ? awbg_pkg::UNITY_GAIN : g;
	endfunction

	function automatic awbg_pkg::awbg_out_t predict_gains(input awbg_pkg::awbg_in_t req);
		logic [15:0] rr, br, rg, gg, bg, g_b, g_r;
		logic f;
		awbg_pkg::awbg_out_t res;
		rr = req.red_ratio;
		br = req.blue_ratio;
		f = 1'b0;
		if (br < typ_b) begin
			if (rr < typ_r) begin
				gg = awbg_pkg::UNITY_GAIN;
				bg = muldiv(awbg_pkg::UNITY_GAIN, typ_b, br, f);
				rg = muldiv(awbg_pkg::UNITY_GAIN, typ_r, rr, f);
			end else begin
				rg = awbg_pkg::UNITY_GAIN;
				gg = muldiv(awbg_pkg::UNITY_GAIN, rr, typ_r, f);
				bg = muldiv(gg, typ_b, br, f);
			end
		end else if (rr < typ_r) begin
			bg = awbg_pkg::UNITY_GAIN;
			gg = muldiv(awbg_pkg::UNITY_GAIN, br, typ_b, f);
			rg = muldiv(gg, typ_r, rr, f);
		end else begin
			// both at or above typical: larger green wins, tie goes to red
			g_b = muldiv(awbg_pkg::UNITY_GAIN, br, typ_b, f);
			g_r = muldiv(awbg_pkg::UNITY_GAIN, rr, typ_r, f);
			if (g_b > g_r) begin
				bg = awbg_pkg::UNITY_GAIN;
				gg = g_b;
				rg = muldiv(gg, typ_r, rr, f);
			end else begin
				rg = awbg_pkg::UNITY_GAIN;
				gg = g_r;
				bg = muldiv(gg, typ_b, br, f);
			end
		end
		res.red_gain = clamp_unity(rg);
		res.green_gain = clamp_unity(gg);
		res.blue_gain = clamp_unity(bg);
		res.divide_fault = f;
		return res;
	endfunction

	// Driver: present the head of the pending queue, predict on accept
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && !in_stall) begin
			expected_gains.push_back(predict_gains(in_data));
			void'(pending_reqs.pop_front());
		end
		if (!in_valid || !in_stall) begin
			// the head is the next request, whether or not one was just taken
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		awbg_pkg::awbg_out_t exp_res;
		if (out_valid && !out_stall) begin
			if (expected_gains.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				errors = errors + 1;
			end else begin
				exp_res = expected_gains.pop_front();
				if (out_data.red_gain !== exp_res.red_gain) begin
					$error("red_gain exp %h got %h", exp_res.red_gain, out_data.red_gain);
					errors = errors + 1;
				end
				if (out_data.green_gain !== exp_res.green_gain) begin
					$error("green_gain exp %h got %h", exp_res.green_gain,
						out_data.green_gain);
					errors = errors + 1;
				end
				if (out_data.blue_gain !== exp_res.blue_gain) begin
					$error("blue_gain exp %h got %h", exp_res.blue_gain, out_data.blue_gain);
					errors = errors + 1;
				end
				if (out_data.divide_fault !== exp_res.divide_fault) begin
					$error("divide_fault exp %b got %b", exp_res.divide_fault,
						out_data.divide_fault);
					errors = errors + 1;
				end
			end
		end
	end

	// Timeout watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_req(input logic [15:0] r, input logic [15:0] b);
		awbg_pkg::awbg_in_t req;
		req.red_ratio = r;
		req.blue_ratio = b;
		pending_reqs.push_back(req);
	endtask

	// Let everything drain, then a margin for the pipeline
	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_gains.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_typ(input awbg_pkg::cfg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == awbg_pkg::CFG_TYP_R)
			typ_r = val;
		else
			typ_b = val;
	endtask

	// Mostly ratios near the typical values so every case branch is hit
	function automatic logic [15:0] pick_ratio(input logic [15:0] typ);
		int sel;
		int v;
		sel = $urandom_range(9);
		if (sel == 0)
			return 16'($urandom);
		if (sel == 1)
			return 16'($urandom_range(3));
		if (sel == 2)
			return typ;
		v = int'(typ) + $urandom_range(2 * int'(typ) + 8) - int'(typ) - 4;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic random_phase(input int n, input int ip, input int sp);
		idle_pct = ip;
		stall_pct = sp;
		repeat (n) add_req(pick_ratio(typ_r), pick_ratio(typ_b));
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, all four cases, ties, zero divisors, saturation
		add_req(16'd0, 16'd0);
		add_req(16'hFFFF, 16'hFFFF);
		add_req(16'd0, 16'hFFFF);
		add_req(16'hFFFF, 16'd0);
		add_req(awbg_pkg::TYP_R_RESET, awbg_pkg::TYP_B_RESET);
		add_req(16'(awbg_pkg::TYP_R_RESET - 16'd1), 16'(awbg_pkg::TYP_B_RESET - 16'd1));
		add_req(16'(awbg_pkg::TYP_R_RESET + 16'd100),
			16'(awbg_pkg::TYP_B_RESET - 16'd100));
		add_req(16'(awbg_pkg::TYP_R_RESET - 16'd100),
			16'(awbg_pkg::TYP_B_RESET + 16'd100));
		add_req(16'd1170, 16'd1124);  // equal green candidates
		add_req(16'd1, 16'd1);
		add_req(16'hFFFF, 16'd1);
		add_req(16'h5555, 16'hAAAA);
		add_req(16'hAAAA, 16'h5555);
		drain();

		random_phase(250, 0, 0);
		write_typ(awbg_pkg::CFG_TYP_R, 16'd1);
		write_typ(awbg_pkg::CFG_TYP_B, 16'hFFFF);
		random_phase(200, 63, 0);
		write_typ(awbg_pkg::CFG_TYP_R, 16'hFFFF);
		write_typ(awbg_pkg::CFG_TYP_B, 16'd1);
		random_phase(200, 0, 63);
		// typical ratios of zero: every division by them faults
		write_typ(awbg_pkg::CFG_TYP_R, 16'd0);
		write_typ(awbg_pkg::CFG_TYP_B, 16'd0);
		random_phase(100, 11, 11);
		write_typ(awbg_pkg::CFG_TYP_R, 16'($urandom_range(1, 4000)));
		write_typ(awbg_pkg::CFG_TYP_B, 16'($urandom_range(1, 4000)));
		random_phase(200, 11, 11);

		// Long receiver hold-off while requests keep coming: queue must fill
		idle_pct = 0;
		stall_pct = 0;
		hold_off = 300;
		random_phase(150, 0, 0);

		write_typ(awbg_pkg::CFG_TYP_R, awbg_pkg::TYP_R_RESET);
		write_typ(awbg_pkg::CFG_TYP_B, awbg_pkg::TYP_B_RESET);
		random_phase(200, 11, 11);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

### filelist.f
rtl/awbg_pkg.sv
rtl/awbg_div.sv
rtl/awbg_front.sv
rtl/awbg_queue.sv
rtl/awbg_back.sv
rtl/awb_gain_from_otp_ratios.sv
tb/tb_top.sv
